// ===== sv/dbra_pkg.sv =====
// Package for the drunken bishop random-art unit.
// Holds board sizes, codes, state encoding and the cell position helper.
// No dependencies.
package dbra_pkg;

  localparam int MAX_CELLS = 512;
  localparam int ADDR_W    = $clog2(MAX_CELLS);
  localparam int POS_W     = 9;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 5;
  localparam int COUNT_W   = 8;
  localparam int SYM_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 32;

  localparam logic [COL_W-1:0] WIDTH_RST  = 5'd17;
  localparam logic [ROW_W-1:0] HEIGHT_RST = 4'd9;
  localparam logic [SYM_W-1:0] SSH_LIMIT  = 5'd14;
  localparam logic [SYM_W-1:0] GPG_LIMIT  = 5'd18;
  localparam logic [SYM_W-1:0] HEAT_LIMIT = 5'd18;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_WALK  = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STYLE  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_READ,
    S_DONE
  } state_t;

  // row-major cell number: row * w + col
  function automatic logic [POS_W-1:0] cell_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col,
                                                input logic [COL_W-1:0] w);
    logic [POS_W-1:0] prod;
    prod = {{(POS_W-ROW_W){1'b0}}, row} * {{(POS_W-COL_W){1'b0}}, w};
    return prod + {{(POS_W-COL_W){1'b0}}, col};
  endfunction

endpackage

// ===== sv/dbra_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read-before-write on a same-address collision. No dependencies.
module dbra_ram #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/drunken_bishop_random_art_unit.sv =====
// Drunken bishop random-art unit: board RAM, bishop walker, cell reader.
// Uses dbra_pkg and dbra_ram.
// Walk S_WALK, S_TAIL, S_DONE; read S_READ, S_DONE; begin S_CLEAR, S_DONE; other S_DONE.
// A walk does one board read-modify-write per move, 4 moves plus one drain write.
// Begin sweeps the board RAM, one entry per cycle, set by its single write port.
// Reset (rst_n low, synchronous) clears all MAX_CELLS entries; no item is taken until done.
module drunken_bishop_random_art_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [1:0] opcode, [9:2] data_byte, [18:10] cell_index, [23:19] zero
  input  logic [dbra_pkg::IN_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] cell_count, [12:8] symbol_index, [17:13] heat_index,
  // [18] is_start_cell, [19] is_end_cell, [28:20] bishop_position, [31:29] zero
  output logic [dbra_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dbra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbra_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import dbra_pkg::*;

  state_t               state_r, state_nxt;
  logic [COL_W-1:0]     cfg_w_r;
  logic [ROW_W-1:0]     cfg_h_r;
  logic                 cfg_style_r;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [7:0]           data_r, data_nxt;
  logic [POS_W-1:0]     idx_r, idx_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [ADDR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                 clr_begin_r, clr_begin_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [POS_W-1:0]     pend_pos_r, pend_pos_nxt;
  logic                 fwd_r, fwd_nxt;
  logic [COUNT_W-1:0]   fwd_data_r, fwd_data_nxt;
  logic [COUNT_W-1:0]   res_count_r, res_count_nxt;
  logic [SYM_W-1:0]     res_sym_r, res_sym_nxt;
  logic [SYM_W-1:0]     res_heat_r, res_heat_nxt;
  logic                 res_s_r, res_s_nxt;
  logic                 res_e_r, res_e_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic [COL_W-1:0]     w;
  logic [ROW_W-1:0]     h;
  logic [POS_W-1:0]     area;
  logic [POS_W-1:0]     center;
  logic [POS_W-1:0]     cur_pos;
  logic [ROW_W-1:0]     mv_row;
  logic [COL_W-1:0]     mv_col;
  logic [POS_W-1:0]     mv_pos;
  logic [COUNT_W-1:0]   cur_count;
  logic [COUNT_W-1:0]   bump_val;
  logic [SYM_W-1:0]     sym_lim;
  logic                 in_fire;
  logic [1:0]           in_op;

  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [COUNT_W-1:0]   mem_wdata, mem_rdata;

  dbra_ram #(
    .DEPTH  (MAX_CELLS),
    .DATA_W (COUNT_W),
    .ADDR_W (ADDR_W)
  ) u_board (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign w       = cfg_w_r | COL_W'(1);
  assign h       = cfg_h_r | ROW_W'(1);
  assign area    = {{(POS_W-COL_W){1'b0}}, w} * {{(POS_W-ROW_W){1'b0}}, h};
  assign center  = cell_pos(h >> 1, w >> 1, w);
  assign cur_pos = cell_pos(row_r, col_r, w);
  assign sym_lim = cfg_style_r ? SSH_LIMIT : GPG_LIMIT;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_op     = in_tdata[1:0];
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // one diagonal move; slide on an edge, hold in a corner
  always_comb begin
    mv_row = row_r;
    mv_col = col_r;
    if (!data_r[1]) begin
      if (row_r != '0) mv_row = row_r - ROW_W'(1);
    end else begin
      if (({1'b0, row_r} + (ROW_W+1)'(1)) < {1'b0, h}) mv_row = row_r + ROW_W'(1);
    end
    if (!data_r[0]) begin
      if (col_r != '0) mv_col = col_r - COL_W'(1);
    end else begin
      if (({1'b0, col_r} + (COL_W+1)'(1)) < {1'b0, w}) mv_col = col_r + COL_W'(1);
    end
    mv_pos = cell_pos(mv_row, mv_col, w);
  end

  assign cur_count = fwd_r ? fwd_data_r : mem_rdata;
  assign bump_val  = cur_count + COUNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    data_nxt       = data_r;
    idx_nxt        = idx_r;
    step_nxt       = step_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_begin_nxt  = clr_begin_r;
    pend_valid_nxt = pend_valid_r;
    pend_pos_nxt   = pend_pos_r;
    fwd_nxt        = fwd_r;
    fwd_data_nxt   = fwd_data_r;
    res_count_nxt  = res_count_r;
    res_sym_nxt    = res_sym_r;
    res_heat_nxt   = res_heat_r;
    res_s_nxt      = res_s_r;
    res_e_nxt      = res_e_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    mem_we         = 1'b0;
    mem_waddr      = ADDR_W'(pend_pos_r);
    mem_wdata      = bump_val;
    mem_re         = 1'b0;
    mem_raddr      = ADDR_W'(mv_pos);

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = (clr_begin_r && (int'(center) == int'(clr_cnt_r))) ?
                    COUNT_W'(1) : '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(MAX_CELLS - 1)) begin
          state_nxt = clr_begin_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_count_nxt = '0;
          res_sym_nxt   = '0;
          res_heat_nxt  = '0;
          res_s_nxt     = 1'b0;
          res_e_nxt     = 1'b0;
          case (in_op)
            OP_BEGIN: begin
              row_nxt       = h >> 1;
              col_nxt       = w >> 1;
              clr_begin_nxt = 1'b1;
              clr_cnt_nxt   = '0;
              state_nxt     = S_CLEAR;
            end
            OP_WALK: begin
              if (row_r > h - ROW_W'(1)) row_nxt = h - ROW_W'(1);
              if (col_r > w - COL_W'(1)) col_nxt = w - COL_W'(1);
              data_nxt       = in_tdata[9:2];
              step_nxt       = '0;
              pend_valid_nxt = 1'b0;
              fwd_nxt        = 1'b0;
              state_nxt      = S_WALK;
            end
            OP_READ: begin
              mem_re    = 1'b1;
              mem_raddr = ADDR_W'(in_tdata[18:10]);
              idx_nxt   = in_tdata[18:10];
              state_nxt = S_READ;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_WALK: begin
        // write back the previous move while reading this one
        mem_we         = pend_valid_r;
        mem_re         = 1'b1;
        fwd_data_nxt   = bump_val;
        fwd_nxt        = pend_valid_r && (mv_pos == pend_pos_r);
        pend_valid_nxt = int'(mv_pos) < MAX_CELLS;
        pend_pos_nxt   = mv_pos;
        row_nxt        = mv_row;
        col_nxt        = mv_col;
        data_nxt       = data_r >> 2;
        step_nxt       = step_r + 2'd1;
        if (step_r == 2'd3) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        mem_we         = pend_valid_r;
        pend_valid_nxt = 1'b0;
        fwd_nxt        = 1'b0;
        state_nxt      = S_DONE;
      end
      S_READ: begin
        if ((idx_r < area) && (int'(idx_r) < MAX_CELLS)) begin
          res_count_nxt = mem_rdata;
          res_sym_nxt   = (mem_rdata < {3'b0, sym_lim}) ? mem_rdata[SYM_W-1:0] : sym_lim;
          res_heat_nxt  = (mem_rdata < {3'b0, HEAT_LIMIT}) ?
                          mem_rdata[SYM_W-1:0] : HEAT_LIMIT;
          res_s_nxt     = (idx_r == center);
          res_e_nxt     = (idx_r == cur_pos);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b0, cur_pos, res_e_r, res_s_r, res_heat_r, res_sym_r,
                           res_count_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cfg_w_r      <= WIDTH_RST;
      cfg_h_r      <= HEIGHT_RST;
      cfg_style_r  <= 1'b1;
      row_r        <= '0;
      col_r        <= '0;
      step_r       <= '0;
      clr_cnt_r    <= '0;
      clr_begin_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      fwd_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      step_r       <= step_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_begin_r  <= clr_begin_nxt;
      pend_valid_r <= pend_valid_nxt;
      fwd_r        <= fwd_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:  cfg_w_r     <= cfg_data;
          CFG_HEIGHT: cfg_h_r     <= cfg_data[ROW_W-1:0];
          CFG_STYLE:  cfg_style_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r      <= data_nxt;
    idx_r       <= idx_nxt;
    pend_pos_r  <= pend_pos_nxt;
    fwd_data_r  <= fwd_data_nxt;
    res_count_r <= res_count_nxt;
    res_sym_r   <= res_sym_nxt;
    res_heat_r  <= res_heat_nxt;
    res_s_r     <= res_s_nxt;
    res_e_r     <= res_e_nxt;
    out_data_r  <= out_data_nxt;
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result word raised outside the done state");

  a_bishop_on_board: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAIL |-> (row_r <= h - ROW_W'(1)) && (col_r <= w - COL_W'(1)))
    else $error("bishop left the board during a walk");

  a_walk_write_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == S_WALK || state_r == S_TAIL)) |-> pend_pos_r < area)
    else $error("walk write outside the board");

  a_fwd_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> $past(mem_we) && $past(state_r) == S_WALK)
    else $error("forwarded count without a preceding write");

endmodule
